// ===== rtl/core/crf_pkg.sv =====
package crf_pkg;

  localparam int DATA_OUT = 6;
  localparam int ADDR_W   = 4;

  localparam logic [7:0] HEADER_RST  = 8'hEB;
  localparam logic [7:0] TRAILER_RST = 8'hAF;
  localparam logic [7:0] LIMIT_RST   = 8'd15;

  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_TRAILER = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } crf_status_t;

  typedef struct packed {
    logic [7:0]  buttons_high;
    logic [7:0]  buttons_low;
    logic [7:0]  right_y;
    logic [7:0]  right_x;
    logic [7:0]  left_y;
    logic [7:0]  left_x;
    crf_status_t status;
  } crf_result_t;

endpackage

// ===== rtl/core/crf_deframe.sv =====
module crf_deframe #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         header_byte,
  input  logic [7:0]         trailer_byte,
  input  logic [7:0]         hunt_limit,
  output logic               res_valid,
  output crf_pkg::crf_result_t res
);
  import crf_pkg::*;

  localparam int PW = $clog2(PAYLOAD_BYTES + 2);

  logic          in_frame_r, in_frame_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    hunt_r, hunt_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    csum_r, csum_nxt;
  logic [7:0]    payload_r [DATA_OUT];
  logic [7:0]    data_out  [DATA_OUT];
  logic          is_data, is_csum, timeout;
  crf_status_t   status;

  assign is_data = pos_r < PW'(PAYLOAD_BYTES);
  assign is_csum = pos_r == PW'(PAYLOAD_BYTES);

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    hunt_nxt     = hunt_r;
    sum_nxt      = sum_r;
    csum_nxt     = csum_r;
    res_valid    = 1'b0;
    timeout      = 1'b0;
    status       = ST_OK;
    if (byte_valid) begin
      if (!in_frame_r) begin
        if (rx_byte == header_byte) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = '0;
          sum_nxt      = '0;
          hunt_nxt     = '0;
        end else if (hunt_r >= hunt_limit) begin
          hunt_nxt  = '0;
          res_valid = 1'b1;
          timeout   = 1'b1;
          status    = ST_TIMEOUT;
        end else begin
          hunt_nxt = hunt_r + 8'd1;
        end
      end else if (is_data) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + 1'b1;
      end else if (is_csum) begin
        csum_nxt = rx_byte;
        pos_nxt  = pos_r + 1'b1;
      end else begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        hunt_nxt     = '0;
        res_valid    = 1'b1;
        status       = (csum_r == sum_r && rx_byte == trailer_byte) ? ST_OK : ST_BAD;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DATA_OUT; k++) begin
      data_out[k] = (k < PAYLOAD_BYTES && !timeout) ? payload_r[k] : 8'd0;
    end
  end

  assign res.status       = status;
  assign res.left_x       = data_out[0];
  assign res.left_y       = data_out[1];
  assign res.right_x      = data_out[2];
  assign res.right_y      = data_out[3];
  assign res.buttons_low  = data_out[4];
  assign res.buttons_high = data_out[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      hunt_r     <= '0;
      sum_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      hunt_r     <= hunt_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    csum_r <= csum_nxt;
    for (int k = 0; k < DATA_OUT; k++) begin
      if (k < PAYLOAD_BYTES && byte_valid && in_frame_r && is_data && pos_r == PW'(k)) begin
        payload_r[k] <= rx_byte;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(PAYLOAD_BYTES + 1))
    else $error("frame position out of range");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == '0)
    else $error("position nonzero while hunting");

  a_res_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !in_frame_r && hunt_r == '0)
    else $error("result did not leave block hunting with cleared count");

  a_hdr_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !in_frame_r && rx_byte == header_byte) |=> in_frame_r && pos_r == '0)
    else $error("header did not open a frame");
`endif

endmodule

// ===== rtl/core/crf_skid.sv =====
module crf_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  crf_pkg::crf_result_t res,
  output logic                 res_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crf_pkg::crf_result_t out_data
);
  import crf_pkg::*;

  logic        out_valid_r, skid_valid_r;
  crf_result_t out_r, skid_r;
  logic        pop;

  assign pop       = !out_valid_r || out_ready;
  assign res_ready = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> !skid_valid_r && out_valid_r)
    else $error("skid did not move to output");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(skid_valid_r && res_valid))
    else $error("result arrived while skid full");
`endif

endmodule

// ===== rtl/core/controller_frame_receiver.sv =====
// Output: results of bytes that close a frame or time out the hunt reach out_tvalid
//   through the output register, or the skid register while out_tready is low.
// Throughput: one byte per cycle; a two-entry output buffer drops in_tready
//   only while two results wait for out_tready.
// Reset: synchronous on rst_n low; returns to hunting, clears counters and
//   restores the header, trailer and hunt limit registers to their defaults.
module controller_frame_receiver #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_x, left_y, right_x, right_y, buttons_low, buttons_high
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [crf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crf_pkg::*;

  logic [7:0]  header_r, trailer_r, limit_r;
  logic        cfg_wr;
  logic        accept;
  logic        res_valid, res_ready;
  crf_result_t res, out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      trailer_r <= TRAILER_RST;
      limit_r   <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HEADER:  header_r  <= pwdata[7:0];
        REG_TRAILER: trailer_r <= pwdata[7:0];
        REG_LIMIT:   limit_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEADER:  prdata = {24'd0, header_r};
      REG_TRAILER: prdata = {24'd0, trailer_r};
      REG_LIMIT:   prdata = {24'd0, limit_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign in_tready = res_ready;
  assign accept    = in_tvalid && in_tready;

  crf_deframe #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_deframe (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (accept),
    .rx_byte      (in_tdata),
    .header_byte  (header_r),
    .trailer_byte (trailer_r),
    .hunt_limit   (limit_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  crf_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.buttons_high, out_res.buttons_low, out_res.right_y,
                      out_res.right_x, out_res.left_y, out_res.left_x};
  assign out_tuser = out_res.status;

endmodule
